/* rtl/afilt_pkg.sv */
// shared types, codes and hash constants for the receive address filter
`default_nettype none

package afilt_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] KIND_CHECK = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_ADD   = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    // verdict codes
    localparam logic [3:0] VERDICT_INDIVIDUAL = 4'd0;
    localparam logic [3:0] VERDICT_BCAST      = 4'd1;
    localparam logic [3:0] VERDICT_MCAST      = 4'd2;
    localparam logic [3:0] VERDICT_PROMISC    = 4'd3;
    localparam logic [3:0] VERDICT_RX_OFF     = 4'd4;
    localparam logic [3:0] VERDICT_LINK_DOWN  = 4'd5;
    localparam logic [3:0] VERDICT_SHORT      = 4'd6;
    localparam logic [3:0] VERDICT_BCAST_OFF  = 4'd7;
    localparam logic [3:0] VERDICT_MCAST_OFF  = 4'd8;
    localparam logic [3:0] VERDICT_HASH_MISS  = 4'd9;
    localparam logic [3:0] VERDICT_UNKNOWN    = 4'd10;
    localparam logic [3:0] VERDICT_TABLE_OP   = 4'd11;

    // configuration register indexes
    localparam logic [2:0] REG_PROMISC   = 3'd0;
    localparam logic [2:0] REG_BCAST_DIS = 3'd1;
    localparam logic [2:0] REG_MCAST_EN  = 3'd2;
    localparam logic [2:0] REG_MIN_LEN   = 3'd3;
    localparam logic [2:0] REG_STATION   = 3'd4;

    localparam logic [7:0]  MIN_LEN_FLOOR = 8'd5;
    localparam logic [7:0]  MIN_LEN_RESET = 8'd64;
    localparam logic [47:0] BCAST_ADDR    = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;

    // filter settings used by the front part
    typedef struct packed {
        logic        promisc;
        logic        bcast_dis;
        logic [7:0]  min_len;
        logic [47:0] station;
    } t_filter_cfg;

    // classified item passed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic [3:0] verdict;
        logic       mcast_chk;
        logic [5:0] hash_index;
    } t_front_item;

    // bitwise crc over six bytes, first byte first, lsb first in each byte
    function automatic logic [31:0] crc_addr(input logic [47:0] addr,
                                             input logic [31:0] init);
        logic [31:0] crc;
        logic        fb;
        crc = init;
        for (int b = 5; b >= 0; b--) begin
            for (int k = 0; k < 8; k++) begin
                fb  = crc[31] ^ addr[b * 8 + k];
                crc = {crc[30:0], 1'b0};
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
            end
        end
        return crc;
    endfunction

    // address bits that feed hash bit j (crc bit j+2), elaboration only
    function automatic logic [47:0] hash_mask(input int j);
        logic [47:0] mask;
        logic [31:0] crc;
        mask = '0;
        for (int k = 0; k < 48; k++) begin
            crc     = crc_addr(48'd1 << k, 32'd0);
            mask[k] = crc[j + 2];
        end
        return mask;
    endfunction

    // hash of the all-zero address with the all-ones start value
    function automatic logic [5:0] hash_base();
        logic [31:0] crc;
        crc = crc_addr(48'd0, 32'hFFFF_FFFF);
        return crc[7:2];
    endfunction

    localparam logic [5:0] HASH_BASE = hash_base();

endpackage

`default_nettype wire

/* rtl/ethernet_rx_address_filter_unit.sv */
// top level of the receive address filter with multicast hash table
`default_nettype none

// Decides for each received frame header whether the frame is stored, and
// maintains a 64-bit multicast hash table through clear and add items.
// One item is taken per clock when the output side keeps up. A result
// passes through the front stage register, the two-entry queue and the
// output register before it shows on the output. The address hash is a
// fixed xor network. The hash table is updated and read in the back
// stage, so table items and the checks that follow them go through
// without stalls.
// Configuration is written over the APB port at byte address 8*index and
// is meant to be changed only while no items are in flight.
module ethernet_rx_address_filter_unit
    import afilt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // frame_address, frame_length, receiver_enabled, link_up
    input  wire logic [1:0]  s_axis_tuser,  // kind
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // verdict, accepted, group_flag, hash_index, zero fill
);

    logic        r_promisc;
    logic        r_bcast_dis;
    logic        r_mcast_en;
    logic [7:0]  r_min_len;
    logic [47:0] r_station;
    logic [2:0]  w_reg_idx;
    logic        w_cfg_wr;
    t_filter_cfg w_cfg;
    logic        w_f_valid;
    logic        w_f_ready;
    t_front_item w_f_item;
    logic        w_q_valid;
    logic        w_q_ready;
    t_front_item w_q_item;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[5:3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_promisc   <= 1'b0;
            r_bcast_dis <= 1'b0;
            r_mcast_en  <= 1'b0;
            r_min_len   <= MIN_LEN_RESET;
            r_station   <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_PROMISC:   r_promisc   <= pwdata[0];
                REG_BCAST_DIS: r_bcast_dis <= pwdata[0];
                REG_MCAST_EN:  r_mcast_en  <= pwdata[0];
                REG_MIN_LEN:   r_min_len   <= pwdata[7:0];
                REG_STATION:   r_station   <= pwdata[47:0];
                default:       ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_reg_idx)
            REG_PROMISC:   prdata = {63'd0, r_promisc};
            REG_BCAST_DIS: prdata = {63'd0, r_bcast_dis};
            REG_MCAST_EN:  prdata = {63'd0, r_mcast_en};
            REG_MIN_LEN:   prdata = {56'd0, r_min_len};
            REG_STATION:   prdata = {16'd0, r_station};
            default:       prdata = '0;
        endcase
    end

    assign w_cfg.promisc   = r_promisc;
    assign w_cfg.bcast_dis = r_bcast_dis;
    assign w_cfg.min_len   = r_min_len;
    assign w_cfg.station   = r_station;

    afilt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_kind  (s_axis_tuser),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_item  (w_f_item)
    );

    afilt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    afilt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mcast_en (r_mcast_en),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_item     (w_q_item),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

    // result fields for checking
    logic [3:0] w_out_verdict;
    logic       w_out_accepted;
    logic       w_out_group;

    assign w_out_verdict  = m_axis_tdata[3:0];
    assign w_out_accepted = m_axis_tdata[4];
    assign w_out_group    = m_axis_tdata[5];

    // table ops never accept a frame or flag a group
    a_table_op_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_out_verdict == VERDICT_TABLE_OP) |-> !w_out_accepted && !w_out_group)
        else $error("table op result marked accepted or group");

    // group flag only for broadcast or multicast acceptance
    a_group_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_out_group |->
            (w_out_verdict == VERDICT_BCAST) || (w_out_verdict == VERDICT_MCAST))
        else $error("group flag on a non-group verdict");

    // acceptance matches the verdict class
    a_accept_class : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_out_accepted == (w_out_verdict <= VERDICT_PROMISC)))
        else $error("accepted bit disagrees with verdict");

endmodule

`default_nettype wire

/* rtl/afilt_front.sv */
// front part: takes items, hashes the address and pre-classifies the frame
`default_nettype none

module afilt_front
    import afilt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_filter_cfg i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_data,   // frame_address, frame_length, receiver_enabled, link_up
    input  wire logic [1:0]  i_kind,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_front_item      o_item
);

    logic [47:0] w_addr;
    logic [13:0] w_len;
    logic        w_rx_on;
    logic        w_link;
    logic [5:0]  w_idx;
    logic [7:0]  w_min_len;
    t_front_item n_item;
    logic        r_valid;
    t_front_item r_item;

    assign w_addr  = i_data[47:0];
    assign w_len   = i_data[61:48];
    assign w_rx_on = i_data[62];
    assign w_link  = i_data[63];

    // hash index: each bit is the parity of a fixed set of address bits
    for (genvar g = 0; g < 6; g++) begin : g_hash
        localparam logic [47:0] MASK = hash_mask(g);
        assign w_idx[g] = (^(w_addr & MASK)) ^ HASH_BASE[g];
    end

    assign w_min_len = (i_cfg.min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : i_cfg.min_len;

    // classification up to the point where the hash table is needed
    always_comb begin
        n_item.op         = i_kind;
        n_item.mcast_chk  = 1'b0;
        n_item.hash_index = w_idx;
        n_item.verdict    = VERDICT_UNKNOWN;
        priority if (i_kind != KIND_CHECK) begin
            n_item.verdict = VERDICT_TABLE_OP;
            if (i_kind != KIND_ADD) begin
                n_item.hash_index = '0;
            end
        end else if (!w_rx_on) begin
            n_item.verdict = VERDICT_RX_OFF;
        end else if (!w_link) begin
            n_item.verdict = VERDICT_LINK_DOWN;
        end else if (w_len < {6'd0, w_min_len}) begin
            n_item.verdict = VERDICT_SHORT;
        end else if (i_cfg.promisc) begin
            n_item.verdict = VERDICT_PROMISC;
        end else if (w_addr == BCAST_ADDR) begin
            n_item.verdict = i_cfg.bcast_dis ? VERDICT_BCAST_OFF : VERDICT_BCAST;
        end else if (w_addr[40]) begin
            n_item.mcast_chk = 1'b1;
        end else if (w_addr == i_cfg.station) begin
            n_item.verdict = VERDICT_INDIVIDUAL;
        end else begin
            n_item.verdict = VERDICT_UNKNOWN;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // stage register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage register payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/afilt_queue.sv */
// two-entry queue between the front and back parts
`default_nettype none

module afilt_queue
    import afilt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_front_item i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_front_item      o_item
);

    t_front_item r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push;
    logic        w_pop;

    assign o_valid = (r_count != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_ready = (r_count != 2'd2) || w_pop;
    assign w_push  = i_valid && o_ready;
    assign o_item  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/afilt_back.sv */
// back part: owns the hash table, applies table ops, finishes the verdict
`default_nettype none

module afilt_back
    import afilt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_mcast_en,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_front_item i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_data    // verdict, accepted, group_flag, hash_index, zero fill
);

    logic [63:0] r_table;
    logic [63:0] n_table;
    logic [3:0]  n_verdict;
    logic        w_take;
    logic        r_valid;
    logic [3:0]  r_verdict;
    logic        r_accepted;
    logic        r_group;
    logic [5:0]  r_idx;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // final verdict for group addresses
    always_comb begin
        n_verdict = i_item.verdict;
        if (i_item.mcast_chk) begin
            priority if (!i_mcast_en) begin
                n_verdict = VERDICT_MCAST_OFF;
            end else if (!r_table[i_item.hash_index]) begin
                n_verdict = VERDICT_HASH_MISS;
            end else begin
                n_verdict = VERDICT_MCAST;
            end
        end
    end

    // table update
    always_comb begin
        n_table = r_table;
        unique case (i_item.op)
            KIND_CLEAR: n_table = '0;
            KIND_ADD:   n_table = r_table | (64'd1 << i_item.hash_index);
            KIND_CHECK: n_table = r_table;
            KIND_NOP:   n_table = r_table;
        endcase
    end

    // control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_table <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_take) begin
                r_table <= n_table;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_verdict  <= n_verdict;
            r_accepted <= (n_verdict <= VERDICT_PROMISC);
            r_group    <= (n_verdict == VERDICT_BCAST) || (n_verdict == VERDICT_MCAST);
            r_idx      <= i_item.hash_index;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {4'd0, r_idx, r_group, r_accepted, r_verdict};

endmodule

`default_nettype wire
